/* hdl/dpss_pkg.sv */
// Package for the dominance successor search block.
// Holds the table size, item structs, status codes and front-to-back queue entry type.
`timescale 1ns / 1ps
package dpss_pkg;
   localparam int MAX_POINTS = 1024;
   localparam int REF_BITS   = $clog2(MAX_POINTS + 1);
   localparam int COORD_W    = 31;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_REF = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_QUERY  = 1'b1
   } op_type;

   typedef struct packed {
      logic                 operation;
      logic [COORD_W-1:0]   coord_x;
      logic [COORD_W-1:0]   coord_y;
      logic [REF_BITS-1:0]  query_ref;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [REF_BITS-1:0]  answer_ref;
      logic [1:0]           status;
   } rsp_type;

   // Classified job handed from front to back.
   typedef enum logic [1:0] {
      JOB_INSERT = 2'd0,
      JOB_QUERY  = 2'd1,
      JOB_REPLY  = 2'd2
   } job_kind_type;

   typedef struct packed {
      job_kind_type         kind;
      logic [COORD_W-1:0]   coord_x;
      logic [COORD_W-1:0]   coord_y;
      logic [REF_BITS-1:0]  ref_num;
      logic [1:0]           status;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_FETCH = 2'd1,
      BK_SCAN  = 2'd2
   } back_state_type;
endpackage

/* hdl/dpss_front.sv */
// Front end: accepts items, checks references and capacity, queues jobs.
// Depends on dpss_pkg.
`timescale 1ns / 1ps
module dpss_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dpss_pkg::req_type req,
   output logic              busy,
   output logic              job_valid,
   output dpss_pkg::job_type job,
   input  logic              job_take
);
   import dpss_pkg::*;
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       fill_ff, fill_in;
   job_type          q_ff [2];
   logic             rd_ff, rd_in, wr_ff, wr_in;
   job_type          new_job;
   logic             push;
   logic [REF_BITS:0] ref_ext;

   assign busy      = (fill_ff == 2'd2);
   assign push      = start && !busy;
   assign job_valid = (fill_ff != 2'd0);
   assign job       = q_ff[rd_ff];
   assign ref_ext   = {1'b0, req.query_ref};

   // Classify the incoming item.
   always_comb begin
      new_job.coord_x = req.coord_x;
      new_job.coord_y = req.coord_y;
      new_job.ref_num = count_ff[REF_BITS-1:0];
      new_job.status  = STATUS_OK;
      new_job.kind    = JOB_INSERT;
      count_in        = count_ff;
      if (req.operation == OP_INSERT) begin
         if (count_ff >= CNT_W'(MAX_POINTS)) begin
            new_job.kind   = JOB_REPLY;
            new_job.status = STATUS_FULL;
         end else if (push) begin
            count_in = count_ff + CNT_W'(1);
         end
      end else begin
         new_job.ref_num = req.query_ref;
         if (req.query_ref == '0 || (CNT_W + 1)'(ref_ext) > (CNT_W + 1)'(count_ff)) begin
            new_job.kind   = JOB_REPLY;
            new_job.status = STATUS_BAD_REF;
         end else begin
            new_job.kind = JOB_QUERY;
         end
      end
   end

   // Advance queue pointers and fill level.
   always_comb begin
      wr_in   = push ? !wr_ff : wr_ff;
      rd_in   = (job_take && job_valid) ? !rd_ff : rd_ff;
      fill_in = fill_ff + 2'(push) - 2'(job_take && job_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fill_ff  <= '0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         fill_ff  <= fill_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= new_job;
   end
endmodule

/* hdl/dpss_back.sv */
// Back end: point memory, inserts and a sequential scan for queries.
// Depends on dpss_pkg.
`timescale 1ns / 1ps
module dpss_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  dpss_pkg::job_type job,
   output logic              job_take,
   output logic              rsp_strobe,
   output dpss_pkg::rsp_type rsp
);
   import dpss_pkg::*;
   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);

   logic [2*COORD_W-1:0] mem [MAX_POINTS];
   logic [2*COORD_W-1:0] rdata_ff;
   logic [AW-1:0]        raddr;
   logic                 rd_en;

   back_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;     // next address to read
   logic [CNT_W-1:0]  cmp_ff, cmp_in;     // zero-based index of the entry in rdata
   logic [COORD_W-1:0] a_ff, a_in, b_ff, b_in, bx_ff, bx_in, by_ff, by_in;
   logic              have_ff, have_in;
   logic [REF_BITS-1:0] best_ff, best_in;
   logic              wr_en;
   logic [COORD_W-1:0] px, py;
   logic              ok, better;

   assign px = rdata_ff[2*COORD_W-1:COORD_W];
   assign py = rdata_ff[COORD_W-1:0];
   assign ok = (py > b_ff && px >= a_ff) || (py == b_ff && px > a_ff);
   assign better = !have_ff || py < by_ff || (py == by_ff && px < bx_ff);

   // Point memory, registered read.
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[count_ff[AW-1:0]] <= {job.coord_x, job.coord_y};
      if (rd_en) rdata_ff <= mem[raddr];
   end

   // Sequence inserts, replies and the query scan.
   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff; cmp_in = cmp_ff;
      a_in = a_ff; b_in = b_ff; bx_in = bx_ff; by_in = by_ff;
      have_in = have_ff; best_in = best_ff;
      job_take = 1'b0; wr_en = 1'b0; rd_en = 1'b0; raddr = '0;
      rsp_strobe = 1'b0;
      rsp = '{found: 1'b0, answer_ref: '0, status: STATUS_OK};
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               job_take = 1'b1;
               case (job.kind)
                  JOB_INSERT: begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
                  JOB_QUERY: begin
                     rd_en    = 1'b1;
                     raddr    = AW'(job.ref_num - REF_BITS'(1));
                     state_in = BK_FETCH;
                  end
                  default: begin
                     rsp_strobe = 1'b1;
                     rsp.status = job.status;
                  end
               endcase
            end
         end
         BK_FETCH: begin
            // Latch the query point, start reading entry zero.
            a_in     = px;
            b_in     = py;
            rd_en    = 1'b1;
            raddr    = '0;
            idx_in   = CNT_W'(1);
            cmp_in   = '0;
            have_in  = 1'b0;
            state_in = BK_SCAN;
         end
         default: begin
            // Compare the entry on the read port; read the next one.
            if (ok && better) begin
               have_in = 1'b1;
               bx_in   = px;
               by_in   = py;
               best_in = REF_BITS'(cmp_ff + CNT_W'(1));
            end
            cmp_in = cmp_ff + CNT_W'(1);
            if (cmp_ff + CNT_W'(1) >= count_ff) begin
               rsp_strobe     = 1'b1;
               rsp.found      = have_in;
               rsp.answer_ref = have_in ? best_in : '0;
               state_in       = BK_IDLE;
            end else begin
               rd_en  = (idx_ff < count_ff);
               raddr  = idx_ff[AW-1:0];
               idx_in = idx_ff + CNT_W'(1);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; cmp_ff <= cmp_in;
      a_ff <= a_in; b_ff <= b_in; bx_ff <= bx_in; by_ff <= by_in;
      have_ff <= have_in; best_ff <= best_in;
   end
endmodule

/* hdl/dominating_point_successor_search.sv */
// Top level of the dominance successor search block.
// Depends on dpss_pkg, dpss_front and dpss_back.
//
//   channel   handshake          payload
//   request   start / busy       req  (req_type)
//   response  rsp_strobe         rsp  (rsp_type)
//
// An insert is written in the cycle it is taken; a failed insert or bad reference
// answers in the same cycle it is taken from the queue. A query holds the back
// end while it reads the queried point, then latches it and reads entry zero,
// then compares one entry a cycle on the single read port for N stored points;
// the result shows in the cycle of the last compare.
// The two-entry queue accepts new items while a query scans; busy rises when
// it is full. Synchronous reset empties the table; no clearing pass.
// The receiver cannot stall: each result shows for one cycle.
`timescale 1ns / 1ps
module dominating_point_successor_search (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  dpss_pkg::req_type req_item,
   output logic              busy,
   output logic              rsp_strobe,
   output dpss_pkg::rsp_type rsp_item
);
   import dpss_pkg::*;

   logic    job_valid, job_take;
   job_type job;

   dpss_front u_front (
      .clock, .reset, .start, .req(req_item), .busy,
      .job_valid, .job, .job_take
   );

   dpss_back u_back (
      .clock, .reset, .job_valid, .job, .job_take,
      .rsp_strobe, .rsp(rsp_item)
   );

   // A not-found never carries a number, and a found result is always ok.
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.found |-> rsp_item.answer_ref == '0)
      else $error("not-found result with nonzero number");
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.found |-> rsp_item.status == STATUS_OK)
      else $error("found result with error status");
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      job_take |-> job_valid)
      else $error("back end took from empty queue");
endmodule

/* bench/tb_dominating_point_successor_search.sv */
// Testbench for the dominance successor search block.
// Depends on dpss_pkg and dominating_point_successor_search; a scoreboard
// class tracks the point table and checks each answer in order.
`timescale 1ns / 1ps
module tb_dominating_point_successor_search;
   import dpss_pkg::*;

   localparam int MAX_PTS = MAX_POINTS;
   localparam int WATCHDOG_LIMIT = 20000;

   // Track stored points and the answers still due from the block.
   class successor_scoreboard;
      logic [COORD_W-1:0] table_x[MAX_PTS];
      logic [COORD_W-1:0] table_y[MAX_PTS];
      int unsigned stored;
      rsp_type pending[$];
      int errors;

      function void clear();
         stored = 0;
         pending.delete();
         errors = 0;
      endfunction

      // Predict the answer for one accepted item.
      function void note_item(req_type item);
         rsp_type r;
         logic have;
         logic [COORD_W-1:0] ax, by, bx, byy;
         logic [REF_BITS-1:0] best;
         logic hit;
         r = '0;
         if (item.operation == OP_INSERT) begin
            if (stored >= MAX_PTS) begin
               r.status = STATUS_FULL;
               pending.push_back(r);
            end else begin
               table_x[stored] = item.coord_x;
               table_y[stored] = item.coord_y;
               stored++;
            end
            return;
         end
         if (item.query_ref == 0 || item.query_ref > stored) begin
            r.status = STATUS_BAD_REF;
            pending.push_back(r);
            return;
         end
         ax = table_x[item.query_ref - 1];
         by = table_y[item.query_ref - 1];
         have = 1'b0;
         bx = '0;
         byy = '0;
         best = '0;
         for (int j = 0; j < stored; j++) begin
            hit = (table_y[j] > by && table_x[j] >= ax) || (table_y[j] == by && table_x[j] > ax);
            if (hit && (!have || table_y[j] < byy || (table_y[j] == byy && table_x[j] < bx)))
            begin
               have = 1'b1;
               bx = table_x[j];
               byy = table_y[j];
               best = REF_BITS'(j + 1);
            end
         end
         r.found = have;
         r.answer_ref = best;
         r.status = STATUS_OK;
         pending.push_back(r);
      endfunction

      // Compare one answer with the oldest prediction.
      function void check_answer(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report("answer with nothing pending");
            return;
         end
         want = pending.pop_front();
         if (got.found !== want.found)
            report($sformatf("found %0d, want %0d", got.found, want.found));
         if (got.answer_ref !== want.answer_ref)
            report($sformatf("answer_ref %0d, want %0d", got.answer_ref, want.answer_ref));
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
      endfunction

      function void report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endfunction
   endclass

   logic clock;
   logic reset;
   logic start;
   req_type req_item;
   logic busy;
   logic rsp_strobe;
   rsp_type rsp_item;

   successor_scoreboard board;
   int idle_pct;
   int quiet_cycles;
   int unsigned inserted;

   dominating_point_successor_search dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_item(req_item),
      .busy(busy),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Note accepted items and check answers at each edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            board.note_item(req_item);
         if (rsp_strobe)
            board.check_answer(rsp_item);
         quiet_cycles = ((start && !busy) || rsp_strobe) ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // Present one item, wait until accepted, maybe idle afterward.
   task automatic send_item(req_type item);
      start <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      inserted += (item.operation == OP_INSERT) ? 1 : 0;
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         req_item <= '0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic send_insert(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      req_type item;
      item = '0;
      item.operation = OP_INSERT;
      item.coord_x = x;
      item.coord_y = y;
      item.query_ref = REF_BITS'($urandom);
      send_item(item);
   endtask

   task automatic send_query(logic [REF_BITS-1:0] qref);
      req_type item;
      item.operation = OP_QUERY;
      item.coord_x = COORD_W'($urandom);
      item.coord_y = COORD_W'($urandom);
      item.query_ref = qref;
      send_item(item);
   endtask

   // Hold the sender until every answer is in.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0)
         @(posedge clock);
      repeat (MAX_PTS + 10) @(posedge clock);
   endtask

   // Random coordinate: mostly small to force ties and hits, some wide.
   function automatic logic [COORD_W-1:0] pick_coord();
      if ($urandom_range(3) != 0)
         return COORD_W'($urandom_range(15));
      return COORD_W'($urandom);
   endfunction

   task automatic random_phase(int count);
      for (int k = 0; k < count; k++) begin
         if (inserted < 40 || $urandom_range(1) == 0)
            send_insert(pick_coord(), pick_coord());
         else if ($urandom_range(19) == 0)
            send_query(REF_BITS'($urandom));
         else
            send_query(REF_BITS'($urandom_range(1, (inserted < MAX_PTS) ? inserted : MAX_PTS)));
      end
   endtask

   initial begin
      board = new();
      board.clear();
      start = 1'b0;
      req_item = '0;
      idle_pct = 0;
      quiet_cycles = 0;
      inserted = 0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extremes, duplicates, self match.
      send_query(REF_BITS'(1));
      send_query(REF_BITS'(0));
      send_insert('0, '0);
      send_insert({COORD_W{1'b1}}, {COORD_W{1'b1}});
      send_insert(COORD_W'(5), COORD_W'(5));
      send_insert(COORD_W'(5), COORD_W'(5));
      send_insert(COORD_W'(6), COORD_W'(5));
      send_insert(COORD_W'(4), COORD_W'(6));
      send_insert(COORD_W'(5), COORD_W'(7));
      send_query(REF_BITS'(1));
      send_query(REF_BITS'(2));
      send_query(REF_BITS'(3));
      send_query(REF_BITS'(4));
      send_query(REF_BITS'(5));
      send_query(REF_BITS'(6));
      send_query(REF_BITS'(7));
      send_query(REF_BITS'(8));
      send_query({REF_BITS{1'b1}});
      send_query(REF_BITS'(1024));
      drain();

      // Random phases with shifting sender idle rates.
      idle_pct = 26;
      random_phase(400);
      drain();
      idle_pct = 87;
      random_phase(300);
      idle_pct = 0;
      random_phase(400);

      // Fill the table and hit the full case and the top reference.
      while (inserted < MAX_PTS + 3)
         send_insert(pick_coord(), pick_coord());
      send_query(REF_BITS'(MAX_PTS));
      send_query(REF_BITS'(MAX_PTS + 1));
      random_phase(100);
      drain();

      if (board.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
